/* design/ffc_pkg.sv */
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types and constants for the float format converter: command codes,
// fp32 special patterns and the result bundles of the encode/decode units.
// ----------------------------------------------------------------------------
package ffc_pkg;

    // conversion commands
    typedef enum logic [2:0] {
        CMD_F32_TO_F16  = 3'd0,
        CMD_F16_TO_F32  = 3'd1,
        CMD_F32_TO_BF16 = 3'd2,
        CMD_BF16_TO_F32 = 3'd3,
        CMD_F32_TO_F8   = 3'd4,
        CMD_F8_TO_F32   = 3'd5
    } t_cmd;

    localparam int unsigned CMD_W = 3;
    localparam int unsigned WORD_W = 32;

    // fp32 special patterns
    localparam logic [31:0] F32_CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] F32_INF       = 32'h7F80_0000;

    // narrow special patterns
    localparam logic [14:0] F16_INF   = 15'h7C00;
    localparam logic [6:0]  F8_MAXPAT = 7'h7F;

    // encoder results, one per narrow format
    typedef struct packed {
        logic [15:0] fp16;
        logic [15:0] bf16;
        logic [7:0]  fp8;
    } t_enc_res;

    // decoder results, all fp32
    typedef struct packed {
        logic [31:0] from_fp16;
        logic [31:0] from_bf16;
        logic [31:0] from_fp8;
    } t_dec_res;

endpackage

/* design/ffc_encode.sv */
// ----------------------------------------------------------------------------
// ffc_encode
// fp32 to fp16, bf16 and fp8 E4M3 encoders, all evaluated in parallel.
// ----------------------------------------------------------------------------
module ffc_encode (
    input  logic [31:0]       i_value_bits,
    output ffc_pkg::t_enc_res o_enc
);
    import ffc_pkg::*;

    logic        sign;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] m24;

    assign sign = i_value_bits[31];
    assign ex   = i_value_bits[30:23];
    assign man  = i_value_bits[22:0];
    assign m24  = {1'b1, man};

    // fp16: truncate normals, round half up in the subnormal range
    always_comb begin
        logic [7:0]  sh8;
        logic [4:0]  sh;
        logic [4:0]  rb_idx;
        logic [23:0] shifted;
        logic [10:0] sub;
        logic [7:0]  e8;
        sh8     = 8'd126 - ex;
        sh      = sh8[4:0];
        rb_idx  = sh - 5'd1;
        shifted = m24 >> sh;
        sub     = shifted[10:0] + {10'd0, m24[rb_idx]};
        e8      = ex - 8'd112;
        if (ex == 8'hFF) begin
            o_enc.fp16 = {sign, F16_INF[14:1], (man != 23'd0)};
        end else if (ex < 8'd102) begin
            o_enc.fp16 = {sign, 15'd0};
        end else if (ex <= 8'd112) begin
            o_enc.fp16 = {sign, 4'd0, sub};
        end else if (ex >= 8'd143) begin
            o_enc.fp16 = {sign, F16_INF};
        end else begin
            o_enc.fp16 = {sign, e8[4:0], man[22:13]};
        end
    end

    // bf16: round to nearest even, all-ones exponent truncated
    always_comb begin
        logic [15:0] upper;
        logic [15:0] low;
        logic        rnd;
        upper = i_value_bits[31:16];
        low   = i_value_bits[15:0];
        rnd   = (low > 16'h8000) || ((low == 16'h8000) && upper[0]);
        if (ex == 8'hFF) begin
            o_enc.bf16 = upper;
        end else begin
            o_enc.bf16 = upper + {15'd0, rnd};
        end
    end

    // fp8 e4m3: truncate normals, round half up subnormals, saturate to 0x7f
    always_comb begin
        logic [7:0]  sh8;
        logic [4:0]  sh;
        logic [4:0]  rb_idx;
        logic [23:0] shifted;
        logic [3:0]  sub;
        logic [7:0]  e8;
        sh8     = 8'd141 - ex;
        sh      = sh8[4:0];
        rb_idx  = sh - 5'd1;
        shifted = m24 >> sh;
        sub     = shifted[3:0] + {3'd0, m24[rb_idx]};
        e8      = ex - 8'd120;
        if (ex == 8'hFF) begin
            o_enc.fp8 = {sign, F8_MAXPAT};
        end else if (ex < 8'd117) begin
            o_enc.fp8 = {sign, 7'd0};
        end else if (ex <= 8'd120) begin
            o_enc.fp8 = {sign, 3'd0, sub};
        end else if (ex >= 8'd135) begin
            o_enc.fp8 = {sign, F8_MAXPAT};
        end else begin
            o_enc.fp8 = {sign, e8[3:0], man[22:20]};
        end
    end

endmodule

/* design/ffc_decode.sv */
// ----------------------------------------------------------------------------
// ffc_decode
// Exact fp16, bf16 and fp8 E4M3 to fp32 decoders, evaluated in parallel.
// ----------------------------------------------------------------------------
module ffc_decode (
    input  logic [31:0]       i_value_bits,
    output ffc_pkg::t_dec_res o_dec
);
    import ffc_pkg::*;

    // fp16 source
    always_comb begin
        logic        sign;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  p;
        logic [4:0]  lsh;
        logic [23:0] norm;
        logic [7:0]  sub_ex;
        logic [7:0]  nrm_ex;
        sign = i_value_bits[15];
        ex   = i_value_bits[14:10];
        man  = i_value_bits[9:0];
        // leading one position of the subnormal mantissa
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                p = 4'(i);
            end
        end
        lsh    = 5'd23 - {1'b0, p};
        norm   = {14'd0, man} << lsh;
        sub_ex = {4'd0, p} + 8'd103;
        nrm_ex = {3'd0, ex} + 8'd112;
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                o_dec.from_fp16 = {sign, 31'd0};
            end else begin
                o_dec.from_fp16 = {sign, sub_ex, norm[22:0]};
            end
        end else if (ex == 5'd31) begin
            o_dec.from_fp16 = (man != 10'd0) ? F32_CANON_NAN : ({sign, 31'd0} | F32_INF);
        end else begin
            o_dec.from_fp16 = {sign, nrm_ex, man, 13'd0};
        end
    end

    // bf16 source
    always_comb begin
        logic [31:0] x;
        x = {i_value_bits[15:0], 16'd0};
        if ((x[30:23] == 8'hFF) && (x[22:16] != 7'd0)) begin
            o_dec.from_bf16 = F32_CANON_NAN;
        end else begin
            o_dec.from_bf16 = x;
        end
    end

    // fp8 e4m3 source, exponent 15 always nan
    always_comb begin
        logic        sign;
        logic [3:0]  ex;
        logic [2:0]  man;
        logic [1:0]  p;
        logic [4:0]  lsh;
        logic [23:0] norm;
        logic [7:0]  sub_ex;
        logic [7:0]  nrm_ex;
        sign = i_value_bits[7];
        ex   = i_value_bits[6:3];
        man  = i_value_bits[2:0];
        p = 2'd0;
        for (int i = 0; i < 3; i++) begin
            if (man[i]) begin
                p = 2'(i);
            end
        end
        lsh    = 5'd23 - {3'd0, p};
        norm   = {21'd0, man} << lsh;
        sub_ex = {6'd0, p} + 8'd118;
        nrm_ex = {4'd0, ex} + 8'd120;
        if (ex == 4'd0) begin
            if (man == 3'd0) begin
                o_dec.from_fp8 = {sign, 31'd0};
            end else begin
                o_dec.from_fp8 = {sign, sub_ex, norm[22:0]};
            end
        end else if (ex == 4'd15) begin
            o_dec.from_fp8 = F32_CANON_NAN;
        end else begin
            o_dec.from_fp8 = {sign, nrm_ex, man, 20'd0};
        end
    end

endmodule

/* design/float_format_converter_unit.sv */
// ----------------------------------------------------------------------------
// float_format_converter_unit
// Accepted start beats pass the input and result registers to o_valid.
// Throughput: one beat per cycle; busy is held low, the path is fully
// registered (input register, encode/decode logic, result register).
// Reset: synchronous active-low i_rst_n clears the valid flags only.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module float_format_converter_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ffc_pkg::CMD_W-1:0]  i_cmd,
    input  logic [ffc_pkg::WORD_W-1:0] i_value_bits,
    output logic                       o_valid,
    output logic [ffc_pkg::WORD_W-1:0] o_result_bits
);
    import ffc_pkg::*;

    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [WORD_W-1:0] r_value;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_result;
    logic [WORD_W-1:0] n_result;
    logic              accept;

    t_enc_res enc;
    t_dec_res dec;

    // never stalls the sender
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_value <= i_value_bits;
        end
    end

    ffc_encode u_encode (
        .i_value_bits (r_value),
        .o_enc        (enc)
    );

    ffc_decode u_decode (
        .i_value_bits (r_value),
        .o_dec        (dec)
    );

    // pick the result for the command
    always_comb begin
        case (t_cmd'(r_cmd))
            CMD_F32_TO_F16:  n_result = {16'd0, enc.fp16};
            CMD_F16_TO_F32:  n_result = dec.from_fp16;
            CMD_F32_TO_BF16: n_result = {16'd0, enc.bf16};
            CMD_BF16_TO_F32: n_result = dec.from_bf16;
            CMD_F32_TO_F8:   n_result = {24'd0, enc.fp8};
            CMD_F8_TO_F32:   n_result = dec.from_fp8;
            default:         n_result = '0;
        endcase
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_bits = r_result;

endmodule
